>>> rtl/pded_pkg.sv
`timescale 1ns / 1ps

package pded_pkg;

    // Request codes on the action field
    typedef enum logic [1:0] {
        ACT_TICK        = 2'd0,
        ACT_TAKE_DETECT = 2'd1,
        ACT_TAKE_LEAVE  = 2'd2,
        ACT_CLEAR       = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLED         = 2'd0,
        CFG_DWELL_THRESHOLD = 2'd1,
        CFG_LEAVE_TIMEOUT   = 2'd2,
        CFG_UNUSED          = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_DATA_WIDTH = 16;
    localparam int unsigned START_OUT_WIDTH = 32;

    // Control flags of the detector
    typedef struct packed {
        logic sensor_state;
        logic barrier_valid;
        logic leave_timer_valid;
        logic detected_once;
        logic detect_flag;
        logic leave_flag;
    } det_flags_t;

    localparam det_flags_t FLAGS_CLEAR = '{default: 1'b0};

endpackage

>>> rtl/presence_dwell_event_detector.sv
// Presence dwell event detector. Each request on the input channel is a sensor tick
// (action 0, with sensor_level), a take of the pending detect event (1), a take of the
// pending leave event (2) or a clear (3); every request yields exactly one result
// carrying the taken flag, the qualified barrier state, both pending flags and the
// tick count at which the current barrier began. One request is accepted per cycle:
// the detector state is updated by a single pass of logic (one increment, a subtract
// and compare against each threshold) and the result is held in an output register,
// so the result appears in the cycle after acceptance and a new request is taken
// whenever that register is empty or being emptied. Configuration writes (enabled,
// dwell_threshold, leave_timeout) are always ready and take effect on the next cycle.
`timescale 1ns / 1ps

module presence_dwell_event_detector #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [pded_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           action,
    input  logic                                 sensor_level,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 event_taken,
    output logic                                 barrier_now,
    output logic                                 detect_pending,
    output logic                                 leave_pending,
    output logic [pded_pkg::START_OUT_WIDTH-1:0] barrier_start_time
);

    localparam int unsigned CW = pded_pkg::CFG_DATA_WIDTH;
    localparam int unsigned OW = pded_pkg::START_OUT_WIDTH;

    logic                   enabled_reg;
    logic [CW-1:0]          dwell_threshold_reg;
    logic [CW-1:0]          leave_timeout_reg;

    logic [TIME_WIDTH-1:0]  tick_count_reg,    tick_count_next;
    logic [TIME_WIDTH-1:0]  barrier_start_reg, barrier_start_next;
    logic [TIME_WIDTH-1:0]  leave_start_reg,   leave_start_next;
    pded_pkg::det_flags_t   flags_reg,         flags_next;

    logic                   out_valid_reg;
    logic                   event_taken_reg,   event_taken_next;
    logic [OW-1:0]          start_time_reg,    start_time_next;

    logic                   in_fire;
    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  barrier_elapsed;
    logic [TIME_WIDTH-1:0]  leave_elapsed;
    logic                   dwell_passed;
    logic                   timeout_passed;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign now             = tick_count_reg + TIME_WIDTH'(1);
    assign barrier_elapsed = now - barrier_start_reg;
    assign leave_elapsed   = now - leave_start_reg;
    assign dwell_passed    = barrier_elapsed > TIME_WIDTH'(dwell_threshold_reg);
    assign timeout_passed  = leave_elapsed > TIME_WIDTH'(leave_timeout_reg);

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        barrier_start_next = barrier_start_reg;
        leave_start_next   = leave_start_reg;
        flags_next         = flags_reg;
        event_taken_next   = 1'b0;

        case (pded_pkg::action_t'(action))
            pded_pkg::ACT_TICK:
            begin
                tick_count_next = now;
                if (enabled_reg && !flags_reg.leave_flag)
                begin
                    if (sensor_level == flags_reg.sensor_state)
                    begin
                        if (!sensor_level)
                        begin
                            if (flags_reg.leave_timer_valid && timeout_passed)
                            begin
                                flags_next.leave_flag = 1'b1;
                            end
                        end
                        else if (flags_reg.barrier_valid && !flags_reg.detected_once
                                 && dwell_passed)
                        begin
                            flags_next.detected_once = 1'b1;
                            flags_next.detect_flag   = 1'b1;
                        end
                    end
                    else if (sensor_level)
                    begin
                        // beam blocked: stop any leave timer, keep an earlier start
                        flags_next.sensor_state      = 1'b1;
                        flags_next.leave_timer_valid = 1'b0;
                        if (!flags_reg.barrier_valid)
                        begin
                            flags_next.barrier_valid = 1'b1;
                            barrier_start_next       = now;
                        end
                    end
                    else if (flags_reg.barrier_valid && dwell_passed)
                    begin
                        flags_next.sensor_state = 1'b0;
                        if (leave_timeout_reg == '0)
                        begin
                            flags_next.leave_flag = 1'b1;
                        end
                        else
                        begin
                            flags_next.leave_timer_valid = 1'b1;
                            leave_start_next             = now;
                        end
                    end
                    else
                    begin
                        // barrier too short: drop everything
                        flags_next         = pded_pkg::FLAGS_CLEAR;
                        barrier_start_next = '0;
                        leave_start_next   = '0;
                    end
                end
            end
            pded_pkg::ACT_TAKE_DETECT:
            begin
                if (enabled_reg && flags_reg.detect_flag)
                begin
                    flags_next.detect_flag = 1'b0;
                    event_taken_next       = 1'b1;
                end
            end
            pded_pkg::ACT_TAKE_LEAVE:
            begin
                if (enabled_reg && flags_reg.leave_flag)
                begin
                    flags_next.leave_flag = 1'b0;
                    event_taken_next      = 1'b1;
                end
            end
            default:
            begin
                flags_next         = pded_pkg::FLAGS_CLEAR;
                barrier_start_next = '0;
                leave_start_next   = '0;
            end
        endcase

        start_time_next = flags_next.barrier_valid ? OW'(barrier_start_next) : '0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg         <= 1'b1;
            dwell_threshold_reg <= '0;
            leave_timeout_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pded_pkg::cfg_index_t'(cfg_index))
                pded_pkg::CFG_ENABLED:         enabled_reg         <= cfg_data[0];
                pded_pkg::CFG_DWELL_THRESHOLD: dwell_threshold_reg <= cfg_data;
                pded_pkg::CFG_LEAVE_TIMEOUT:   leave_timeout_reg   <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Detector state, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            barrier_start_reg <= '0;
            leave_start_reg   <= '0;
            flags_reg         <= pded_pkg::FLAGS_CLEAR;
        end
        else if (in_fire)
        begin
            tick_count_reg    <= tick_count_next;
            barrier_start_reg <= barrier_start_next;
            leave_start_reg   <= leave_start_next;
            flags_reg         <= flags_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            event_taken_reg <= event_taken_next;
            start_time_reg  <= start_time_next;
        end
    end

    // Flags in the result mirror the state left by the last request
    assign out_valid          = out_valid_reg;
    assign event_taken        = event_taken_reg;
    assign barrier_now        = flags_reg.sensor_state;
    assign detect_pending     = flags_reg.detect_flag;
    assign leave_pending      = flags_reg.leave_flag;
    assign barrier_start_time = start_time_reg;

    a_detect_needs_once : assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.detect_flag |-> flags_reg.detected_once)
        else $error("detect pending without a qualified barrier");

    a_leave_timer_needs_barrier : assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.leave_timer_valid |-> flags_reg.barrier_valid)
        else $error("leave timer running without a barrier start");

    a_once_needs_barrier : assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.detected_once |-> flags_reg.barrier_valid)
        else $error("detection latched without a barrier start");

    a_tick_advances : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == pded_pkg::ACT_TICK)
        |=> tick_count_reg == $past(tick_count_reg) + TIME_WIDTH'(1))
        else $error("tick request did not advance the tick count");

    a_detect_take : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action == pded_pkg::ACT_TAKE_DETECT && enabled_reg
         && flags_reg.detect_flag)
        |=> out_valid_reg && event_taken_reg && !flags_reg.detect_flag)
        else $error("pending detect event not consumed by take request");

endmodule
